### rtl/pscp_pkg.sv
package pscp_pkg;

  localparam int MAX_OPS = 64;
  localparam logic [6:0] OPS_LIMIT = 7'(MAX_OPS - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [30:0] DELAY_MAX = 31'h7fff_ffff;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DELAY = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic [30:0] delay_us;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } scan_out_t;

  // match positions
  localparam logic [4:0] POS_IDLE      = 5'd0;
  localparam logic [4:0] POS_SET_FIRST = 5'd1;
  localparam logic [4:0] POS_ADDR_HI   = 5'd9;
  localparam logic [4:0] POS_ADDR_LO   = 5'd10;
  localparam logic [4:0] POS_VAL_HI    = 5'd14;
  localparam logic [4:0] POS_VAL_LO    = 5'd15;
  localparam logic [4:0] POS_SET_LAST  = 5'd17;
  localparam logic [4:0] POS_UD_FIRST  = 5'd18;
  localparam logic [4:0] POS_UD_LAST   = 5'd23;
  localparam logic [4:0] POS_UD_DIGIT1 = 5'd24;
  localparam logic [4:0] POS_UD_DIGITS = 5'd25;
  localparam logic [4:0] POS_UD_CLOSE  = 5'd26;

  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // expected byte of "setphy(0xHH,0xHH);" at a non-hex position
  function automatic logic [7:0] set_char(input logic [4:0] p);
    logic [7:0] c;
    unique case (p)
      5'd1:    c = 8'h65;
      5'd2:    c = 8'h74;
      5'd3:    c = 8'h70;
      5'd4:    c = 8'h68;
      5'd5:    c = 8'h79;
      5'd6:    c = 8'h28;
      5'd7:    c = CH_ZERO;
      5'd8:    c = 8'h78;
      5'd11:   c = 8'h2c;
      5'd12:   c = CH_ZERO;
      5'd13:   c = 8'h78;
      5'd16:   c = CH_RPAR;
      5'd17:   c = CH_SEMI;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // expected byte of "udelay(" after the leading u
  function automatic logic [7:0] ud_char(input logic [4:0] p);
    logic [7:0] c;
    unique case (p)
      5'd18:   c = 8'h64;
      5'd19:   c = 8'h65;
      5'd20:   c = 8'h6c;
      5'd21:   c = 8'h61;
      5'd22:   c = 8'h79;
      5'd23:   c = 8'h28;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - CH_ZERO;
    end else begin
      v = c - CH_LA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

### rtl/pscp_in_if.sv
interface pscp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       final_req;

  modport source (output valid, output ch, output first, output final_req, input ready);
  modport sink (input valid, input ch, input first, input final_req, output ready);
endinterface

### rtl/pscp_out_if.sv
interface pscp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reg_addr;
  logic [7:0]  reg_value;
  logic [30:0] delay_us;
  logic        last_of_run;

  modport source (output valid, output kind, output reg_addr, output reg_value,
                  output delay_us, output last_of_run, input ready);
  modport sink (input valid, input kind, input reg_addr, input reg_value,
                input delay_us, input last_of_run, output ready);
endinterface

### rtl/pscp_scanner.sv
module pscp_scanner import pscp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] ch,
  input  logic      first,
  input  logic      final_req,
  output scan_out_t res
);

  typedef enum logic [1:0] {EV_NONE, EV_WRITE, EV_DELAY, EV_END} ev_t;

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [30:0] dly_r, dly_nxt;
  logic [6:0]  ops_r, ops_nxt;
  logic        fin_r, fin_nxt;

  logic [4:0]  p;
  logic        fin_eff;
  logic        matched;
  logic        end_now;
  ev_t         ev;
  logic [34:0] dly_wide;
  scan_out_t   r;

  always_comb begin
    p        = first ? POS_IDLE : pos_r;
    fin_eff  = first ? 1'b0 : fin_r;
    ops_nxt  = first ? 7'd0 : ops_r;
    addr_nxt = first ? 8'd0 : addr_r;
    val_nxt  = first ? 8'd0 : val_r;
    dly_nxt  = first ? 31'd0 : dly_r;
    fin_nxt  = fin_eff;
    pos_nxt  = p;
    matched  = 1'b0;
    end_now  = 1'b0;
    ev       = EV_NONE;
    r        = '0;
    dly_wide = ({4'd0, dly_nxt} << 3) + ({4'd0, dly_nxt} << 1)
             + {31'd0, hex_val(ch)};

    if (!fin_eff) begin
      if (p >= POS_SET_FIRST && p <= POS_SET_LAST) begin
        if (p == POS_ADDR_HI || p == POS_ADDR_LO || p == POS_VAL_HI || p == POS_VAL_LO) begin
          if (is_hex(ch)) begin
            if (p <= POS_ADDR_LO) begin
              addr_nxt = {addr_nxt[3:0], hex_val(ch)};
            end else begin
              val_nxt = {val_nxt[3:0], hex_val(ch)};
            end
            pos_nxt = p + 5'd1;
            matched = 1'b1;
          end
        end else if (ch == set_char(p)) begin
          matched = 1'b1;
          if (p == POS_SET_LAST) begin
            pos_nxt = POS_IDLE;
            ev      = EV_WRITE;
          end else begin
            pos_nxt = p + 5'd1;
          end
        end
      end else if (p >= POS_UD_FIRST && p <= POS_UD_LAST) begin
        if (ch == ud_char(p)) begin
          pos_nxt = p + 5'd1;
          matched = 1'b1;
        end
      end else if (p == POS_UD_DIGIT1) begin
        if (is_digit(ch)) begin
          dly_nxt = {27'd0, hex_val(ch)};
          pos_nxt = POS_UD_DIGITS;
          matched = 1'b1;
        end
      end else if (p == POS_UD_DIGITS) begin
        if (is_digit(ch)) begin
          dly_nxt = (dly_wide > {4'd0, DELAY_MAX}) ? DELAY_MAX : dly_wide[30:0];
          matched = 1'b1;
        end else if (ch == CH_RPAR) begin
          pos_nxt = POS_UD_CLOSE;
          matched = 1'b1;
        end
      end else if (p == POS_UD_CLOSE) begin
        if (ch == CH_SEMI) begin
          pos_nxt = POS_IDLE;
          ev      = EV_DELAY;
          matched = 1'b1;
        end
      end

      // idle or failed: look at the byte afresh
      if (!matched) begin
        pos_nxt = POS_IDLE;
        if (ch == CH_S) begin
          pos_nxt = POS_SET_FIRST;
        end else if (ch == CH_U) begin
          pos_nxt = POS_UD_FIRST;
        end else if (ch == CH_RBRC) begin
          ev = EV_END;
        end
      end

      if (ev == EV_WRITE) begin
        r.r0.kind      = KIND_WRITE;
        r.r0.reg_addr  = addr_nxt;
        r.r0.reg_value = val_nxt;
      end else if (ev == EV_DELAY) begin
        r.r0.kind     = KIND_DELAY;
        r.r0.delay_us = dly_nxt;
      end
      if (ev == EV_WRITE || ev == EV_DELAY) begin
        r.n     = 2'd1;
        ops_nxt = ops_nxt + 7'd1;
        end_now = (ops_nxt >= OPS_LIMIT);
      end

      if (ev == EV_END || end_now || final_req) begin
        if (r.n == 2'd0) begin
          r.r0.kind = KIND_END;
        end else begin
          r.r1.kind = KIND_END;
        end
        r.n     = r.n + 2'd1;
        fin_nxt = 1'b1;
        pos_nxt = POS_IDLE;
      end

      r.r0.last_of_run = (r.n == 2'd1);
      r.r1.last_of_run = (r.n == 2'd2);
    end

    res = r;
    if (!accept) begin
      res.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      ops_r <= 7'd0;
      fin_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      ops_r <= ops_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= addr_nxt;
      val_r  <= val_nxt;
      dly_r  <= dly_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_two_ends_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.n == 2'd2 |-> res.r1.kind == KIND_END && res.r0.kind != KIND_END)
    else $error("second result of a byte is not an end op");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fin_r && !first |-> res.n == 2'd0)
    else $error("result after end of op list");

  a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.n != 2'd0 && (res.r0.kind == KIND_END || res.n == 2'd2)
    |=> fin_r && pos_r == POS_IDLE)
    else $error("end op did not stop the parser");
`endif

endmodule

### rtl/pscp_out_fifo.sv
module pscp_out_fifo import pscp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_out_t push,
  output logic      room2,
  output logic      pop_valid,
  input  logic      pop_ready,
  output result_t   head
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign room2     = (count_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign head      = mem[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> count_r + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop)
                       <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

### rtl/phy_script_command_parser_top.sv
// phy script command parser
// in_chan carries one script byte per item (ch, first, final_req); out_chan
// carries ops (kind, reg_addr, reg_value, delay_us, last_of_run).
// setphy(0xRR,0xVV); gives a write op, udelay(N); a delay op; any '}',
// the last byte or the op limit gives an end op, after which bytes
// are taken and dropped until one with first set.
// each accepted byte updates the match state in the same cycle; its ops
// enter a four-entry result queue; if the queue was empty, the first one
// is on out_chan the cycle after acceptance. a byte gives at most two ops.
// throughput is one byte per cycle while the queue has room for two ops;
// in_chan.ready drops when more than two ops are waiting, so a stalled
// receiver stops the input with three or four ops unread.
// reset (rst_n low, synchronous) empties the queue and puts the parser
// in idle scanning with a zero op count, ready for a script.
module phy_script_command_parser_top import pscp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pscp_in_if.sink    in_chan,
  pscp_out_if.source out_chan
);

  logic      accept;
  logic      room2;
  scan_out_t scan_res;
  result_t   head;

  assign in_chan.ready = room2;
  assign accept        = in_chan.valid && room2;

  pscp_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_chan.ch),
    .first     (in_chan.first),
    .final_req (in_chan.final_req),
    .res       (scan_res)
  );

  pscp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (scan_res),
    .room2     (room2),
    .pop_valid (out_chan.valid),
    .pop_ready (out_chan.ready),
    .head      (head)
  );

  assign out_chan.kind        = head.kind;
  assign out_chan.reg_addr    = head.reg_addr;
  assign out_chan.reg_value   = head.reg_value;
  assign out_chan.delay_us    = head.delay_us;
  assign out_chan.last_of_run = head.last_of_run;

endmodule

### tb/sv/phy_script_command_parser_top_tb.sv
`timescale 1ns / 1ps

module phy_script_command_parser_top_tb;
  import pscp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_REPORTS = 10;
  localparam logic [143:0] SET_FORM = "setphy(0xHH,0xHH);";
  localparam logic [55:0] UD_FORM = "udelay(";

  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_WRITE,
    SCAN_DELAY,
    SCAN_END
  } scan_hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pscp_in_if in_chan ();
  pscp_out_if out_chan ();

  phy_script_command_parser_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  logic [4:0] pos_q;
  logic [7:0] addr_q;
  logic [7:0] value_q;
  logic [30:0] delay_q;
  logic [6:0] op_count_q;
  logic script_done_q;

  result_t expected_ops[$];
  logic [7:0] script_q[$];
  result_t want_op;
  result_t got_op;
  int mismatches = 0;
  int random_sent = 0;
  int idle_cycles = 0;
  int sink_hold = 0;
  bit src_gapless = 1'b0;
  bit snk_gapless = 1'b0;

  function automatic void clear_scan();
    pos_q = POS_IDLE;
    addr_q = '0;
    value_q = '0;
    delay_q = '0;
    op_count_q = '0;
    script_done_q = 1'b0;
  endfunction

  // {valid, nibble} for a lower-case hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b1, 4'(c - "0")};
    end
    if (c >= "a" && c <= "f") begin
      return {1'b1, 4'(c - "a" + 10)};
    end
    return 5'd0;
  endfunction

  function automatic scan_hit_t scan_char(input logic [7:0] c);
    logic [4:0] p;
    logic [7:0] want;
    logic [4:0] hx;
    logic dec;
    logic [34:0] grown;
    p = pos_q;
    hx = hex_digit(c);
    dec = (c >= "0" && c <= "9");
    if (p >= POS_SET_FIRST && p <= POS_SET_LAST) begin
      want = SET_FORM[8 * (POS_SET_LAST - p) +: 8];
      if (want == "H") begin
        if (hx[4]) begin
          if (p <= POS_ADDR_LO) begin
            addr_q = {addr_q[3:0], hx[3:0]};
          end else begin
            value_q = {value_q[3:0], hx[3:0]};
          end
          pos_q = p + 5'd1;
          return SCAN_NONE;
        end
      end else if (c == want) begin
        if (p == POS_SET_LAST) begin
          pos_q = POS_IDLE;
          return SCAN_WRITE;
        end
        pos_q = p + 5'd1;
        return SCAN_NONE;
      end
    end else if (p >= POS_UD_FIRST && p <= POS_UD_LAST) begin
      if (c == UD_FORM[8 * (POS_UD_LAST - p) +: 8]) begin
        pos_q = p + 5'd1;
        return SCAN_NONE;
      end
    end else if (p == POS_UD_DIGIT1) begin
      if (dec) begin
        delay_q = 31'(c - "0");
        pos_q = POS_UD_DIGITS;
        return SCAN_NONE;
      end
    end else if (p == POS_UD_DIGITS) begin
      if (dec) begin
        grown = 35'(delay_q) * 35'd10 + 35'(c - "0");
        delay_q = (grown > 35'(DELAY_MAX)) ? DELAY_MAX : grown[30:0];
        return SCAN_NONE;
      end
      if (c == ")") begin
        pos_q = POS_UD_CLOSE;
        return SCAN_NONE;
      end
    end else if (p == POS_UD_CLOSE) begin
      if (c == ";") begin
        pos_q = POS_IDLE;
        return SCAN_DELAY;
      end
    end
    // failed or idle: the byte is looked at again from scratch
    pos_q = POS_IDLE;
    if (c == "s") begin
      pos_q = POS_SET_FIRST;
    end else if (c == "u") begin
      pos_q = POS_UD_FIRST;
    end else if (c == "}") begin
      return SCAN_END;
    end
    return SCAN_NONE;
  endfunction

  task automatic predict_ops(input logic [7:0] c, input logic first, input logic fin);
    scan_hit_t hit;
    result_t ops [2];
    int n;
    int i;
    n = 0;
    if (first) begin
      clear_scan();
    end
    if (script_done_q) begin
      return;
    end
    hit = scan_char(c);
    if (hit == SCAN_WRITE || hit == SCAN_DELAY) begin
      ops[n] = '0;
      if (hit == SCAN_WRITE) begin
        ops[n].kind = KIND_WRITE;
        ops[n].reg_addr = addr_q;
        ops[n].reg_value = value_q;
      end else begin
        ops[n].kind = KIND_DELAY;
        ops[n].delay_us = delay_q;
      end
      n++;
      op_count_q = op_count_q + 7'd1;
      if (op_count_q >= OPS_LIMIT) begin
        hit = SCAN_END;
      end
    end
    if (hit == SCAN_END || fin) begin
      ops[n] = '0;
      ops[n].kind = KIND_END;
      n++;
      script_done_q = 1'b1;
      pos_q = POS_IDLE;
    end
    if (n > 0) begin
      ops[n - 1].last_of_run = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      expected_ops.push_back(ops[i]);
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic first, input logic fin);
    int gap;
    gap = src_gapless ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch <= c;
    in_chan.first <= first;
    in_chan.final_req <= fin;
    do @(posedge clk); while (!in_chan.ready);
    predict_ops(c, first, fin);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      script_q.push_back(s[i]);
    end
  endtask

  task automatic send_script(input bit with_first, input bit fin_last);
    int i;
    for (i = 0; i < script_q.size(); i++) begin
      send_byte(script_q[i], with_first && i == 0, fin_last && i == script_q.size() - 1);
    end
    script_q.delete();
  endtask

  task automatic send_text(input string s, input bit with_first, input bit fin_last);
    add_text(s);
    send_script(with_first, fin_last);
  endtask

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(0, 15);
    return (d < 10) ? 8'("0" + d) : 8'("a" + d - 10);
  endfunction

  task automatic add_setphy();
    add_text("setphy(0x");
    script_q.push_back(rand_hex());
    script_q.push_back(rand_hex());
    add_text(",0x");
    script_q.push_back(rand_hex());
    script_q.push_back(rand_hex());
    add_text(");");
  endtask

  task automatic add_udelay();
    int digits;
    int i;
    digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
    add_text("udelay(");
    for (i = 0; i < digits; i++) begin
      script_q.push_back(8'("0" + $urandom_range(0, 9)));
    end
    add_text(");");
  endtask

  task automatic add_noise();
    int count;
    int i;
    count = $urandom_range(1, 4);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        script_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0a);
      end else begin
        script_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic add_broken_command();
    int start;
    int idx;
    start = script_q.size();
    if ($urandom_range(0, 1)) begin
      add_setphy();
    end else begin
      add_udelay();
    end
    idx = $urandom_range(start, script_q.size() - 1);
    case ($urandom_range(0, 2))
      0: script_q.delete(idx);
      1: script_q[idx] = script_q[idx] ^ 8'h20;
      default: script_q[idx] = 8'($urandom_range(0, 255));
    endcase
  endtask

  task automatic test_reset_without_first();
    send_text("udelay(0);}", 1'b0, 1'b0);
  endtask

  task automatic test_write_extremes();
    send_text("setphy(0x00,0xff);setphy(0xff,0x00);setphy(0x9a,0x5f);}", 1'b1, 1'b0);
  endtask

  task automatic test_broken_commands();
    send_text("setphy(0xAB,0x01);setphy(ab,01);ssetphy(0x12,0x34);uudelay(5);", 1'b1, 1'b0);
    send_text("udelay();udelay(4 );udelay(8)setphy(0x1}", 1'b0, 1'b0);
    // ignored until the next script
    send_text("udelay(3);}", 1'b0, 1'b0);
    send_text("udelay(12", 1'b1, 1'b0);
    send_text(");udelay(6);}", 1'b1, 1'b0);
  endtask

  task automatic test_delay_saturation();
    send_text("udelay(2147483647);udelay(2147483648);", 1'b1, 1'b0);
    send_text("udelay(99999999999999);udelay(0000000000042);}", 1'b0, 1'b0);
  endtask

  task automatic test_last_byte();
    send_text("setphy(0x7e,0x81);", 1'b1, 1'b1);
    send_text("udelay(1", 1'b1, 1'b1);
    send_text("x", 1'b1, 1'b1);
    send_text("}", 1'b1, 1'b1);
    send_text("a", 1'b1, 1'b0);
  endtask

  task automatic test_op_limit();
    int i;
    for (i = 0; i < 62; i++) begin
      send_text($sformatf("udelay(%0d);", i), i == 0, 1'b0);
    end
    send_text("setphy(0xc3,0x3c);", 1'b0, 1'b1);
    send_text("}", 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    src_gapless = 1'b1;
    sink_hold = 60;
    for (i = 0; i < 24; i++) begin
      send_text("}", 1'b1, 1'b0);
    end
    for (i = 0; i < 4; i++) begin
      send_text("udelay(5);", 1'b1, 1'b1);
    end
    src_gapless = 1'b0;
  endtask

  task automatic test_random_scripts();
    int tokens;
    int pick;
    int i;
    bit use_first;
    bit fin_last;
    while (random_sent < RANDOM_ITEMS) begin
      src_gapless = ($urandom_range(0, 3) == 0);
      tokens = $urandom_range(1, 10);
      for (i = 0; i < tokens; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          add_setphy();
        end else if (pick < 75) begin
          add_udelay();
        end else if (pick < 87) begin
          add_broken_command();
        end else begin
          add_noise();
        end
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        add_text("}");
        if ($urandom_range(0, 1)) begin
          add_noise();
        end
      end
      use_first = ($urandom_range(0, 9) != 0);
      fin_last = (pick == 1 || pick == 2);
      random_sent += script_q.size();
      send_script(use_first, fin_last);
    end
    src_gapless = 1'b0;
  endtask

  // result receiver
  initial begin : op_sink
    int w;
    out_chan.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      if ($urandom_range(0, 31) == 0) begin
        snk_gapless = !snk_gapless;
      end
      w = snk_gapless ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_chan.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_op.kind = kind_t'(out_chan.kind);
      got_op.reg_addr = out_chan.reg_addr;
      got_op.reg_value = out_chan.reg_value;
      got_op.delay_us = out_chan.delay_us;
      got_op.last_of_run = out_chan.last_of_run;
      if (expected_ops.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected op: kind %0d addr %02h value %02h delay %0d last %0b",
                   got_op.kind, got_op.reg_addr, got_op.reg_value, got_op.delay_us,
                   got_op.last_of_run);
        end
        mismatches++;
      end else begin
        want_op = expected_ops.pop_front();
        if (got_op.kind !== want_op.kind || got_op.reg_addr !== want_op.reg_addr ||
            got_op.reg_value !== want_op.reg_value || got_op.delay_us !== want_op.delay_us ||
            got_op.last_of_run !== want_op.last_of_run) begin
          if (mismatches < MAX_REPORTS) begin
            $display("op mismatch: want kind %0d addr %02h value %02h delay %0d last %0b",
                     want_op.kind, want_op.reg_addr, want_op.reg_value, want_op.delay_us,
                     want_op.last_of_run);
            $display("             got  kind %0d addr %02h value %02h delay %0d last %0b",
                     got_op.kind, got_op.reg_addr, got_op.reg_value, got_op.delay_us,
                     got_op.last_of_run);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.ch = '0;
    in_chan.first = 1'b0;
    in_chan.final_req = 1'b0;
    clear_scan();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_without_first();
    test_write_extremes();
    test_broken_commands();
    test_delay_saturation();
    test_last_byte();
    test_op_limit();
    test_backpressure();
    test_random_scripts();
    in_chan.valid <= 1'b0;
    while (expected_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_ops.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
